>>> src/expert_cache_lru_policy_macros.svh
// ----------------------------------------------------------------------------
// expert_cache_lru_policy assertion macros
// shared concurrent assertion forms for the lru policy block
// ----------------------------------------------------------------------------
`ifndef EXPERT_CACHE_LRU_POLICY_MACROS_SVH
`define EXPERT_CACHE_LRU_POLICY_MACROS_SVH

// same-cycle implication, disabled in reset
`define ECLP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eclp assertion failed");

// next-cycle implication, disabled in reset
`define ECLP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eclp assertion failed");

`endif

>>> src/eclp_pkg.sv
// ----------------------------------------------------------------------------
// eclp_pkg
// sizes and command codes of the expert cache lru policy
// ----------------------------------------------------------------------------
package eclp_pkg;

  localparam int EXPERT_SLOTS = 32;
  localparam int MAX_EVICT    = 32;

  localparam int IDX_W = $clog2(EXPERT_SLOTS);
  localparam int CNT_W = $clog2(EXPERT_SLOTS + 1);
  localparam int K_W   = $clog2(MAX_EVICT + 1);
  localparam int ID_W  = 5;
  localparam int CMD_W = 2;
  localparam int CFG_W = 6;

  localparam logic [CFG_W-1:0] MAX_RES_RST = CFG_W'(32);

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_TOUCH  = 2'd1,
    CMD_SWEEP  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_FIN  = 3'b100
  } state_t;

endpackage

>>> src/expert_cache_lru_policy.sv
// ----------------------------------------------------------------------------
// expert_cache_lru_policy
// lru residency policy for an expert cache with an eviction limit
// ----------------------------------------------------------------------------
// Commands are taken when start is high and busy is low; every result beat is
// shown for one cycle with out_valid and must be taken then, there is no
// backpressure. Inserts of absent experts, touches of absent experts, NOP
// commands and sweeps with nothing to evict finish in the accept cycle, with
// the result registered for the next cycle and busy staying low. A touch or an
// insert of a resident expert, and each eviction of a sweep, is one pass over
// the recency list memory (single write port, registered read): with n experts
// resident it keeps busy high through the scan of the n entries in S_SCAN and
// then S_FIN, the result beat being registered out of S_FIN. A sweep runs one
// such pass per evicted expert, back to back, at most MAX_EVICT per sweep.
// ----------------------------------------------------------------------------
`include "expert_cache_lru_policy_macros.svh"

module expert_cache_lru_policy (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [eclp_pkg::CMD_W-1:0] in_cmd,
  input  logic [eclp_pkg::ID_W-1:0]  in_expert_id,
  output logic                       out_valid,
  output logic                       out_was_resident,
  output logic                       out_evict_valid,
  output logic [eclp_pkg::ID_W-1:0]  out_evicted_id,
  output logic                       out_last_result,
  input  logic                       cfg_we,
  input  logic [eclp_pkg::CFG_W-1:0] cfg_wdata
);
  import eclp_pkg::*;

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [EXPERT_SLOTS-1:0] flags_r, flags_nxt;
  logic [CFG_W-1:0]        cfg_max_r;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    iss_r, iss_nxt;
  logic                    rdv_r, rdv_nxt;
  logic [IDX_W-1:0]        rdpos_r, rdpos_nxt;
  logic                    found_r, found_nxt;
  logic [ID_W-1:0]         victim_r, victim_nxt;
  logic [ID_W-1:0]         eid_r, eid_nxt;
  logic                    evop_r, evop_nxt;
  logic [K_W-1:0]          k_r, k_nxt;

  logic                    ov_r, ov_nxt;
  logic                    owas_r, owas_nxt;
  logic                    oev_r, oev_nxt;
  logic [ID_W-1:0]         oid_r, oid_nxt;
  logic                    olast_r, olast_nxt;

  logic [ID_W-1:0]         mem [EXPERT_SLOTS];
  logic [ID_W-1:0]         rd_data_r;
  logic                    mem_we;
  logic [IDX_W-1:0]        mem_wa;
  logic [ID_W-1:0]         mem_wd;

  logic [IDX_W-1:0]        last_idx;
  logic [IDX_W-1:0]        eidx;
  logic                    inrange;
  logic                    match;
  logic [CNT_W-1:0]        cnt_dec;
  logic [K_W-1:0]          k_inc;
  logic                    more;

  assign last_idx = IDX_W'(count_r - CNT_W'(1));
  assign eidx     = IDX_W'(in_expert_id);
  assign inrange  = int'(in_expert_id) < EXPERT_SLOTS;
  assign match    = evop_r ? (rdpos_r == '0) : (rd_data_r == eid_r);
  assign cnt_dec  = count_r - CNT_W'(1);
  assign k_inc    = k_r + K_W'(1);
  assign more     = (int'(cnt_dec) > int'(cfg_max_r)) && (int'(k_inc) < MAX_EVICT);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    flags_nxt  = flags_r;
    idx_nxt    = idx_r;
    iss_nxt    = iss_r;
    rdv_nxt    = 1'b0;
    rdpos_nxt  = idx_r;
    found_nxt  = found_r;
    victim_nxt = victim_r;
    eid_nxt    = eid_r;
    evop_nxt   = evop_r;
    k_nxt      = k_r;
    ov_nxt     = 1'b0;
    owas_nxt   = owas_r;
    oev_nxt    = oev_r;
    oid_nxt    = oid_r;
    olast_nxt  = olast_r;
    mem_we     = 1'b0;
    mem_wa     = '0;
    mem_wd     = '0;

    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          eid_nxt   = in_expert_id;
          // default result beat: empty, last
          ov_nxt    = 1'b1;
          owas_nxt  = 1'b0;
          oev_nxt   = 1'b0;
          oid_nxt   = '0;
          olast_nxt = 1'b1;
          unique case (cmd_t'(in_cmd))
            CMD_SWEEP: begin
              if (int'(count_r) > int'(cfg_max_r)) begin
                ov_nxt    = 1'b0;
                evop_nxt  = 1'b1;
                k_nxt     = '0;
                state_nxt = S_SCAN;
                idx_nxt   = '0;
                iss_nxt   = 1'b1;
                found_nxt = 1'b0;
              end
            end
            CMD_INSERT, CMD_TOUCH: begin
              if (inrange && flags_r[eidx]) begin
                // resident: move to tail through a list pass
                ov_nxt    = 1'b0;
                evop_nxt  = 1'b0;
                state_nxt = S_SCAN;
                idx_nxt   = '0;
                iss_nxt   = 1'b1;
                found_nxt = 1'b0;
              end else if (inrange && cmd_t'(in_cmd) == CMD_INSERT &&
                           int'(count_r) < EXPERT_SLOTS) begin
                mem_we          = 1'b1;
                mem_wa          = IDX_W'(count_r);
                mem_wd          = in_expert_id;
                flags_nxt[eidx] = 1'b1;
                count_nxt       = count_r + CNT_W'(1);
              end
            end
            CMD_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (iss_r) begin
          rdv_nxt   = 1'b1;
          rdpos_nxt = idx_r;
          if (idx_r == last_idx) begin
            iss_nxt = 1'b0;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
        if (rdv_r) begin
          // entries after the target shift down one place
          if (found_r) begin
            mem_we = 1'b1;
            mem_wa = rdpos_r - IDX_W'(1);
            mem_wd = rd_data_r;
          end else if (match) begin
            found_nxt = 1'b1;
            if (evop_r) begin
              victim_nxt = rd_data_r;
            end
          end
          if (rdpos_r == last_idx) begin
            state_nxt = S_FIN;
          end
        end
      end

      S_FIN: begin
        ov_nxt = 1'b1;
        if (evop_r) begin
          count_nxt                     = cnt_dec;
          flags_nxt[IDX_W'(victim_r)]   = 1'b0;
          k_nxt                         = k_inc;
          owas_nxt                      = 1'b0;
          oev_nxt                       = 1'b1;
          oid_nxt                       = victim_r;
          olast_nxt                     = !more;
          if (more) begin
            state_nxt = S_SCAN;
            idx_nxt   = '0;
            iss_nxt   = 1'b1;
            found_nxt = 1'b0;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          mem_we    = 1'b1;
          mem_wa    = last_idx;
          mem_wd    = eid_r;
          owas_nxt  = 1'b1;
          oev_nxt   = 1'b0;
          oid_nxt   = '0;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      flags_r   <= '0;
      cfg_max_r <= MAX_RES_RST;
      idx_r     <= '0;
      iss_r     <= 1'b0;
      rdv_r     <= 1'b0;
      found_r   <= 1'b0;
      evop_r    <= 1'b0;
      k_r       <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      flags_r <= flags_nxt;
      if (cfg_we) begin
        cfg_max_r <= cfg_wdata;
      end
      idx_r   <= idx_nxt;
      iss_r   <= iss_nxt;
      rdv_r   <= rdv_nxt;
      found_r <= found_nxt;
      evop_r  <= evop_nxt;
      k_r     <= k_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdpos_r  <= rdpos_nxt;
    victim_r <= victim_nxt;
    eid_r    <= eid_nxt;
    owas_r   <= owas_nxt;
    oev_r    <= oev_nxt;
    oid_r    <= oid_nxt;
    olast_r  <= olast_nxt;
  end

  // recency list, oldest at entry 0
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[idx_r];
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = ov_r;
  assign out_was_resident = owas_r;
  assign out_evict_valid  = oev_r;
  assign out_evicted_id   = oid_r;
  assign out_last_result  = olast_r;

  `ECLP_ASSERT_IMP(a_cnt_max, clk, rst_n, 1'b1, int'(count_r) <= EXPERT_SLOTS)
  `ECLP_ASSERT_IMP(a_flags_cnt, clk, rst_n, state_r == S_IDLE, $countones(flags_r) == int'(count_r))
  `ECLP_ASSERT_IMP(a_more_beats, clk, rst_n, ov_r && !olast_r, state_r == S_SCAN)
  `ECLP_ASSERT_NXT(a_fin_beat, clk, rst_n, state_r == S_FIN, ov_r)

endmodule

>>> sim/tb_expert_cache_lru_policy.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_expert_cache_lru_policy
// self-checking bench for the expert cache lru policy: a class tracks the
// recency list, resident flags and eviction limit, predicts every result beat
// of each accepted command and checks the beats as they leave the block
// ----------------------------------------------------------------------------
module tb_expert_cache_lru_policy;
  import eclp_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic            was_resident;
    logic            evict_valid;
    logic [ID_W-1:0] evicted_id;
    logic            last_mark;
  } policy_beat_t;

  class lru_scoreboard;
    logic [ID_W-1:0] order_q [EXPERT_SLOTS];  // resident experts, oldest first
    bit              resident [EXPERT_SLOTS];
    int              live_cnt;
    int              keep_limit;
    policy_beat_t    pending [$];
    int              errors;

    function new();
      live_cnt   = 0;
      keep_limit = int'(MAX_RES_RST);
      errors     = 0;
      foreach (resident[i]) begin
        resident[i] = 1'b0;
        order_q[i]  = '0;
      end
    endfunction

    function void set_limit(logic [CFG_W-1:0] v);
      keep_limit = int'(v);
    endfunction

    function void note_command(cmd_t c, logic [ID_W-1:0] id);
      policy_beat_t b;
      int           k;
      int           pos;
      int           i;
      b = '0;
      b.last_mark = 1'b1;
      if (c == CMD_SWEEP) begin
        k = 0;
        while (live_cnt > keep_limit && k < MAX_EVICT) begin
          b.evict_valid = 1'b1;
          b.evicted_id  = order_q[0];
          b.last_mark   = 1'b0;
          for (i = 0; i + 1 < live_cnt; i++) order_q[i] = order_q[i + 1];
          live_cnt--;
          resident[b.evicted_id] = 1'b0;
          pending.insert(pending.size(), b);
          k++;
        end
        if (k == 0) begin
          pending.insert(pending.size(), b);
        end else begin
          pending[pending.size() - 1].last_mark = 1'b1;
        end
      end else if ((c == CMD_INSERT || c == CMD_TOUCH) && int'(id) < EXPERT_SLOTS) begin
        b.was_resident = resident[id];
        if (resident[id]) begin
          // move to most recent
          pos = 0;
          while (pos < live_cnt && order_q[pos] != id) pos++;
          if (pos < live_cnt) begin
            for (i = pos; i + 1 < live_cnt; i++) order_q[i] = order_q[i + 1];
            order_q[live_cnt - 1] = id;
          end
        end else if (c == CMD_INSERT && live_cnt < EXPERT_SLOTS) begin
          resident[id]      = 1'b1;
          order_q[live_cnt] = id;
          live_cnt++;
        end
        pending.insert(pending.size(), b);
      end else begin
        pending.insert(pending.size(), b);
      end
    endfunction

    function void compare_field(string fname, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $display("%0t: mismatch on %s, expected %0d, actual %0d", $time, fname, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_beat(policy_beat_t got);
      policy_beat_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual %p", $time, got);
        errors++;
      end else begin
        want = pending[0];
        pending.delete(0);
        compare_field("was_resident", want.was_resident, got.was_resident);
        compare_field("evict_valid", want.evict_valid, got.evict_valid);
        compare_field("evicted_id", want.evicted_id, got.evicted_id);
        compare_field("last_result", want.last_mark, got.last_mark);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             start;
  logic             busy;
  logic [CMD_W-1:0] in_cmd;
  logic [ID_W-1:0]  in_expert_id;
  logic             out_valid;
  logic             out_was_resident;
  logic             out_evict_valid;
  logic [ID_W-1:0]  out_evicted_id;
  logic             out_last_result;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  lru_scoreboard sb;
  int            cycle_count;

  expert_cache_lru_policy uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_expert_id     (in_expert_id),
    .out_valid        (out_valid),
    .out_was_resident (out_was_resident),
    .out_evict_valid  (out_evict_valid),
    .out_evicted_id   (out_evicted_id),
    .out_last_result  (out_last_result),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result beats cannot be held off, every strobe is checked on its edge
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_beat({out_was_resident, out_evict_valid, out_evicted_id, out_last_result});
    end
  end

  // called at a falling edge, returns at the falling edge after the command is accepted
  task automatic issue_command(cmd_t c, logic [ID_W-1:0] id);
    start        = 1'b1;
    in_cmd       = c;
    in_expert_id = id;
    do @(posedge clk); while (busy);
    sb.note_command(c, id);
    @(negedge clk);
  endtask

  task automatic maybe_pause();
    if ($urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (sb.pending.size() != 0 || busy) @(negedge clk);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] v);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = v;
    sb.set_limit(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // random expert, steered toward one that is (or is not) resident
  function automatic logic [ID_W-1:0] pick_expert(bit want_resident);
    logic [ID_W-1:0] id;
    int              n;
    id = ID_W'($urandom_range(0, EXPERT_SLOTS - 1));
    for (n = 0; n < EXPERT_SLOTS; n++) begin
      if (sb.resident[id] == want_resident) return id;
      id = id + 1'b1;
    end
    return id;
  endfunction

  task automatic random_command();
    int              r;
    cmd_t            c;
    logic [ID_W-1:0] id;
    r  = $urandom_range(0, 99);
    id = ID_W'($urandom_range(0, EXPERT_SLOTS - 1));
    if (r < 45) begin
      c = CMD_INSERT;
      if ($urandom_range(0, 9) < 7) id = pick_expert(1'b0);
    end else if (r < 72) begin
      c = CMD_TOUCH;
      if ($urandom_range(0, 9) < 7) id = pick_expert(1'b1);
    end else if (r < 90) begin
      c = CMD_SWEEP;
    end else if (r < 95) begin
      c = CMD_NOP;
    end else begin
      c = cmd_t'($urandom_range(0, 3));
    end
    issue_command(c, id);
  endtask

  // load every expert, then sweep down to the current limit
  task automatic fill_and_sweep(bit pauses);
    while (sb.live_cnt < EXPERT_SLOTS) begin
      if (pauses) maybe_pause();
      issue_command(CMD_INSERT, pick_expert(1'b0));
    end
    issue_command(CMD_SWEEP, ID_W'($urandom_range(0, EXPERT_SLOTS - 1)));
  endtask

  initial begin
    int               limits [7];
    bit               fills [7];
    logic [CFG_W-1:0] v;
    int               p;
    sb           = new();
    cycle_count  = 0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_cmd       = CMD_INSERT;
    in_expert_id = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    limits       = '{32, 63, 0, 1, 33, 31, 0};
    fills        = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: empty sweep, nop command, absent touch, re-insert, touches
    issue_command(CMD_SWEEP, 5'd31);
    issue_command(CMD_NOP, 5'd17);
    issue_command(CMD_TOUCH, 5'd0);
    issue_command(CMD_INSERT, 5'd0);
    issue_command(CMD_INSERT, 5'd31);
    issue_command(CMD_INSERT, 5'd0);
    issue_command(CMD_TOUCH, 5'd31);
    issue_command(CMD_TOUCH, 5'd5);
    issue_command(CMD_INSERT, 5'd10);
    issue_command(CMD_INSERT, 5'd21);
    issue_command(CMD_INSERT, 5'd5);
    issue_command(CMD_TOUCH, 5'd0);
    issue_command(CMD_SWEEP, 5'd0);
    write_limit(6'd2);
    issue_command(CMD_SWEEP, 5'd12);
    write_limit(6'd63);
    issue_command(CMD_INSERT, 5'd7);
    issue_command(CMD_SWEEP, 5'd0);
    write_limit(6'd0);
    issue_command(CMD_SWEEP, 5'd31);
    issue_command(CMD_SWEEP, 5'd0);

    // random phases, the last one without any idling
    for (p = 0; p < 7; p++) begin
      v = (p == 6) ? CFG_W'($urandom_range(0, 63)) : CFG_W'(limits[p]);
      write_limit(v);
      if (fills[p]) fill_and_sweep(p != 6);
      repeat (34) begin
        if (p != 6) maybe_pause();
        random_command();
      end
    end

    wait_idle();
    repeat (EXPERT_SLOTS + 8) @(negedge clk);
    if (sb.pending.size() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time, sb.pending.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/eclp_pkg.sv
src/expert_cache_lru_policy.sv
sim/tb_expert_cache_lru_policy.sv
